>>> design/assert_macros.svh
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked property with reset disable
`define ASSERT_CLK(label, ck, rs, prop, msg) \
  label: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);
`endif

>>> design/lppd_pkg.sv
// shared types and constants of the lidar deskew core
package lppd_pkg;

  localparam int X_W     = 24;
  localparam int TH_W    = 16;
  localparam int AZ_W    = 16;
  localparam int TOFF_W  = 16;
  localparam int CFG_W   = 17;
  localparam int CMD_W   = 2;
  localparam int ST_W    = 2;
  localparam int SIN_W   = 17;
  localparam int Q_FRAC  = 14;

  localparam int POSE_DEPTH_DEF  = 64;
  localparam int AZ_PER_POSE_DEF = 180;

  localparam logic [CMD_W-1:0] CMD_POSE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SCAN  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POINT = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_NEG   = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  localparam logic REG_SENSOR_X = 1'b0;
  localparam logic REG_SENSOR_Y = 1'b1;

  localparam int PHASE_MUL   = 83443;
  localparam int PHASE_ROUND = 32768;
  localparam int ROT_ROUND   = 8192;
  localparam int SIN_A       = 25736;
  localparam int SIN_B       = 10543;
  localparam int SIN_C       = 1191;
  localparam int QUARTER     = 16384;

  typedef struct packed {
    logic signed [X_W-1:0]  x;
    logic signed [X_W-1:0]  y;
    logic signed [TH_W-1:0] theta;
  } pose_t;

  typedef struct packed {
    logic             valid;
    logic [CMD_W-1:0] cmd;
    logic [ST_W-1:0]  status;
  } side_t;

endpackage

>>> design/lppd_ring.sv
// pose ring memory, one write port and two registered read ports
module lppd_ring import lppd_pkg::*; #(
  parameter int DEPTH = POSE_DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  pose_t         wdata,
  input  logic [AW-1:0] raddr_new,
  input  logic [AW-1:0] raddr_old,
  output pose_t         rdata_new,
  output pose_t         rdata_old
);

  pose_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_new <= mem[raddr_new];
    rdata_old <= mem[raddr_old];
  end

endmodule

>>> design/lppd_cdiv.sv
// pipelined division of a magnitude by a constant, reciprocal with correction
module lppd_cdiv import lppd_pkg::*; #(
  parameter int W = 17,
  parameter int DIV = AZ_PER_POSE_DEF,
  localparam int DW = $clog2(DIV + 1)
) (
  input  logic                clk,
  input  logic [W-1:0]        mag,
  input  logic                neg,
  output logic signed [W:0]   quo,
  output logic [DW-1:0]       rem
);

  localparam int SH = W;
  localparam longint unsigned RECIP = (64'd1 << SH) / DIV;
  localparam int RW = $clog2(RECIP + 1);
  localparam int LO = (W + 1) / 2;
  localparam int HI = W - LO;

  logic [LO+RW-1:0] p_lo;
  logic [HI+RW-1:0] p_hi;
  logic [W-1:0]     mag_a;
  logic             neg_a;
  logic [W+RW-1:0]  sum_b;
  logic [W-1:0]     q_b;
  logic [W-1:0]     mag_b;
  logic             neg_b;
  logic [W+DW-1:0]  prod_c;
  logic [W+DW-1:0]  r_c;
  logic             fix_c;
  logic [W-1:0]     q_c;
  logic [W+DW-1:0]  r_fix;

  // partial products
  always_ff @(posedge clk) begin
    p_lo  <= (LO+RW)'(mag[LO-1:0]) * (LO+RW)'(RECIP);
    p_hi  <= (HI+RW)'(mag[W-1:LO]) * (HI+RW)'(RECIP);
    mag_a <= mag;
    neg_a <= neg;
  end

  assign sum_b = ((W+RW)'(p_hi) << LO) + (W+RW)'(p_lo);

  // quotient estimate, low by at most one
  always_ff @(posedge clk) begin
    q_b   <= W'(sum_b >> SH);
    mag_b <= mag_a;
    neg_b <= neg_a;
  end

  assign prod_c = (W+DW)'(q_b) * (W+DW)'(DIV);
  assign r_c    = (W+DW)'(mag_b) - prod_c;
  assign fix_c  = (r_c >= (W+DW)'(DIV));
  assign q_c    = q_b + W'(fix_c);
  assign r_fix  = fix_c ? r_c - (W+DW)'(DIV) : r_c;

  always_ff @(posedge clk) begin
    quo <= neg_b ? -$signed({1'b0, q_c}) : $signed({1'b0, q_c});
    rem <= DW'(r_fix);
  end

endmodule

>>> design/lppd_sine.sv
// pipelined q14 sine from a 16 bit turn phase, polynomial per quarter wave
module lppd_sine import lppd_pkg::*; (
  input  logic                    clk,
  input  logic [15:0]             phase,
  output logic signed [SIN_W-1:0] sine
);

  logic [14:0] r1, r2, r3, r4;
  logic        neg1, neg2, neg3, neg4;
  logic [14:0] x2_2, x2_3;
  logic [13:0] t1_3;
  logic [14:0] t2_4;
  logic [29:0] sq_p;
  logic [25:0] c_p;
  logic [28:0] t_p;
  logic [29:0] s_p;
  logic [15:0] s_mag;

  always_ff @(posedge clk) begin
    r1   <= phase[14] ? 15'(QUARTER) - {1'b0, phase[13:0]} : {1'b0, phase[13:0]};
    neg1 <= phase[15];
  end

  assign sq_p = 30'(r1) * 30'(r1);

  always_ff @(posedge clk) begin
    x2_2 <= sq_p[28:14];
    r2   <= r1;
    neg2 <= neg1;
  end

  assign c_p = 26'(x2_2) * 26'(SIN_C);

  always_ff @(posedge clk) begin
    t1_3 <= 14'(SIN_B) - 14'(c_p[25:14]);
    x2_3 <= x2_2;
    r3   <= r2;
    neg3 <= neg2;
  end

  assign t_p = 29'(x2_3) * 29'(t1_3);

  always_ff @(posedge clk) begin
    t2_4 <= 15'(SIN_A) - t_p[28:14];
    r4   <= r3;
    neg4 <= neg3;
  end

  assign s_p   = 30'(r4) * 30'(t2_4);
  assign s_mag = s_p[29:14];

  always_ff @(posedge clk) begin
    sine <= neg4 ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
  end

endmodule

>>> design/lidar_point_pose_deskew_core.sv
// top level of the lidar point motion deskew core
// Usage: one command transaction (cmd, in_x, in_y, in_theta, azimuth, time_offset)
// is taken at each rising edge with start high and busy low; busy stays low, so a
// transaction can be issued every cycle. cmd 0 stores a pose in the pose ring,
// cmd 1 latches the reference azimuth and time offset, cmd 2 corrects a point.
// Every transaction gives exactly one result on out_x, out_y, status, marked by
// done for one cycle, in issue order. Pose and scan transactions return zeros
// with status 0; errors return zeros with status.
// Throughput is one transaction per cycle: the pose ring is read at two addresses
// and written at one in the same pipeline stage, so ring accesses stay in order.
// Sensor offsets are written through wr_en, wr_index, wr_data while idle.
// Reset (rst, synchronous) clears the ring pointer, pose count, scan reference,
// sensor offsets and flushes the pipeline; ring contents are valid once written.
// The receiver cannot stall: each result must be taken in its done cycle.
`include "assert_macros.svh"
module lidar_point_pose_deskew_core import lppd_pkg::*; #(
  parameter int POSE_DEPTH = POSE_DEPTH_DEF,
  parameter int AZ_PER_POSE = AZ_PER_POSE_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [CMD_W-1:0]         cmd,
  input  logic signed [X_W-1:0]    in_x,
  input  logic signed [X_W-1:0]    in_y,
  input  logic signed [TH_W-1:0]   in_theta,
  input  logic [AZ_W-1:0]          azimuth,
  input  logic signed [TOFF_W-1:0] time_offset,
  input  logic                     wr_en,
  input  logic                     wr_index,
  input  logic [CFG_W-1:0]         wr_data,
  output logic                     done,
  output logic signed [X_W-1:0]    out_x,
  output logic signed [X_W-1:0]    out_y,
  output logic [ST_W-1:0]          status
);

  localparam int HW    = $clog2(POSE_DEPTH);
  localparam int CW    = $clog2(POSE_DEPTH + 1);
  localparam int WW    = $clog2(AZ_PER_POSE + 1);
  localparam int OFF_W = AZ_W + 2;
  localparam int OM_W  = AZ_W + 1;
  localparam int DX_W  = X_W + 1;
  localparam int DT_W  = TH_W + 1;
  localparam int PX_W  = DX_W + WW + 1;
  localparam int PT_W  = DT_W + WW + 1;
  localparam int PM_W  = X_W + WW;
  localparam int TM_W  = TH_W + WW;
  localparam int PS_W  = X_W + 2;
  localparam int RP_W  = SIN_W + PS_W;
  localparam int LAT   = 18;

  // architectural state
  logic [HW-1:0]            head;
  logic [HW-1:0]            head_inc;
  logic [CW-1:0]            count;
  logic [AZ_W-1:0]          ref_az;
  logic signed [TOFF_W-1:0] scan_off;
  logic signed [CFG_W-1:0]  sox;
  logic signed [CFG_W-1:0]  soy;

  logic                     accept;
  logic signed [OFF_W-1:0]  off_now;

  // pipeline
  side_t                    side_q   [1:LAT-1];
  logic signed [X_W-1:0]    x_q      [1:9];
  logic signed [X_W-1:0]    y_q      [1:9];
  logic signed [TH_W-1:0]   th_q     [1:4];
  logic [HW-1:0]            head_q   [1:4];
  logic [CW-1:0]            count_q  [1:4];
  logic                     neg_q    [1:4];
  logic [OM_W-1:0]          off_mag1;

  logic signed [OM_W:0]     quo_off;
  logic [WW-1:0]            rem_off;
  logic [OM_W-1:0]          num;
  logic                     range_err;
  logic [ST_W-1:0]          st4;
  logic [HW+1:0]            a_sum;
  logic [HW-1:0]            raddr_new;
  logic [HW-1:0]            raddr_old;
  logic                     ring_we;
  pose_t                    ring_wdata;
  pose_t                    rd_new;
  pose_t                    rd_old;
  logic [WW-1:0]            w5;

  logic signed [DX_W-1:0]   dx;
  logic signed [DX_W-1:0]   dy;
  logic signed [DT_W-1:0]   dt;
  logic signed [WW:0]       w_s;
  logic signed [PX_W-1:0]   px6;
  logic signed [PX_W-1:0]   py6;
  logic signed [PT_W-1:0]   pt6;
  logic signed [X_W-1:0]    ox_q     [6:9];
  logic signed [X_W-1:0]    oy_q     [6:9];
  logic signed [TH_W-1:0]   ot_q     [6:9];
  logic signed [PM_W:0]     quo_x;
  logic signed [PM_W:0]     quo_y;
  logic signed [TM_W:0]     quo_t;

  logic signed [PS_W-1:0]   px_q     [10:16];
  logic signed [PS_W-1:0]   py_q     [10:16];
  logic signed [DT_W-1:0]   th10;
  logic signed [35:0]       ph_full;
  logic [15:0]              phase11;
  logic signed [SIN_W-1:0]  sin16;
  logic signed [SIN_W-1:0]  cos16;

  logic signed [RP_W-1:0]   cpx, spy, spx, cpy;
  logic signed [RP_W:0]     rx_full, ry_full, rx_off, ry_off;
  logic                     ok17;

  function automatic logic signed [X_W-1:0] sat_x(input logic signed [RP_W:0] v);
    logic signed [RP_W:0] hi;
    logic signed [RP_W:0] lo;
    hi = (RP_W+1)'((1 <<< (X_W - 1)) - 1);
    lo = -(RP_W+1)'(1 <<< (X_W - 1));
    if (v > hi) begin
      return X_W'(hi);
    end else if (v < lo) begin
      return X_W'(lo);
    end
    return X_W'(v);
  endfunction

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign head_inc = (head == HW'(POSE_DEPTH - 1)) ? '0 : head + 1'b1;
  assign off_now  = $signed({2'b00, ref_az}) - $signed({2'b00, azimuth}) + OFF_W'(scan_off);

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= '0;
      ref_az   <= '0;
      scan_off <= '0;
      sox      <= '0;
      soy      <= '0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_SENSOR_X: sox <= $signed(wr_data);
          REG_SENSOR_Y: soy <= $signed(wr_data);
          default: ;
        endcase
      end
      if (accept) begin
        case (cmd)
          CMD_POSE: begin
            head <= head_inc;
            if (count < CW'(POSE_DEPTH)) begin
              count <= count + 1'b1;
            end
          end
          CMD_SCAN: begin
            ref_az   <= azimuth;
            scan_off <= time_offset;
          end
          default: ;
        endcase
      end
    end
  end

  // control sideband
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k < LAT; k++) begin
        side_q[k] <= '0;
      end
      done <= 1'b0;
    end else begin
      side_q[1] <= '{valid: accept, cmd: cmd, status: ST_OK};
      for (int k = 2; k <= 4; k++) begin
        side_q[k] <= side_q[k-1];
      end
      side_q[5] <= '{valid: side_q[4].valid, cmd: side_q[4].cmd,
                     status: (side_q[4].cmd == CMD_POINT) ? st4 : ST_OK};
      for (int k = 6; k < LAT; k++) begin
        side_q[k] <= side_q[k-1];
      end
      done <= side_q[LAT-1].valid;
    end
  end

  // payload delay lines
  always_ff @(posedge clk) begin
    x_q[1]     <= in_x;
    y_q[1]     <= in_y;
    th_q[1]    <= in_theta;
    head_q[1]  <= head;
    count_q[1] <= count;
    neg_q[1]   <= off_now[OFF_W-1];
    off_mag1   <= off_now[OFF_W-1] ? '0 : OM_W'(off_now);
    for (int k = 2; k <= 9; k++) begin
      x_q[k] <= x_q[k-1];
      y_q[k] <= y_q[k-1];
    end
    for (int k = 2; k <= 4; k++) begin
      th_q[k]    <= th_q[k-1];
      head_q[k]  <= head_q[k-1];
      count_q[k] <= count_q[k-1];
      neg_q[k]   <= neg_q[k-1];
    end
  end

  lppd_cdiv #(.W(OM_W), .DIV(AZ_PER_POSE)) u_div_off (
    .clk (clk),
    .mag (off_mag1),
    .neg (1'b0),
    .quo (quo_off),
    .rem (rem_off)
  );

  // interval select and ring addressing
  assign num       = quo_off[OM_W-1:0];
  assign range_err = ((OM_W+1)'(num) + (OM_W+1)'(2)) > (OM_W+1)'(count_q[4]);
  assign st4       = neg_q[4] ? ST_NEG : (range_err ? ST_RANGE : ST_OK);
  assign a_sum     = (HW+2)'(head_q[4]) + (HW+2)'(POSE_DEPTH - 1) - (HW+2)'(num[HW-1:0]);
  assign raddr_new = HW'((a_sum >= (HW+2)'(POSE_DEPTH)) ? a_sum - (HW+2)'(POSE_DEPTH) : a_sum);
  assign raddr_old = (raddr_new == '0) ? HW'(POSE_DEPTH - 1) : raddr_new - 1'b1;
  assign ring_we   = side_q[4].valid && (side_q[4].cmd == CMD_POSE);
  assign ring_wdata = '{x: x_q[4], y: y_q[4], theta: th_q[4]};

  lppd_ring #(.DEPTH(POSE_DEPTH)) u_ring (
    .clk       (clk),
    .we        (ring_we),
    .waddr     (head_q[4]),
    .wdata     (ring_wdata),
    .raddr_new (raddr_new),
    .raddr_old (raddr_old),
    .rdata_new (rd_new),
    .rdata_old (rd_old)
  );

  always_ff @(posedge clk) begin
    w5 <= WW'(AZ_PER_POSE) - rem_off;
  end

  // weighted pose differences
  assign dx  = DX_W'($signed(rd_new.x)) - DX_W'($signed(rd_old.x));
  assign dy  = DX_W'($signed(rd_new.y)) - DX_W'($signed(rd_old.y));
  assign dt  = DT_W'($signed(rd_new.theta)) - DT_W'($signed(rd_old.theta));
  assign w_s = $signed({1'b0, w5});

  always_ff @(posedge clk) begin
    px6     <= PX_W'(dx) * PX_W'(w_s);
    py6     <= PX_W'(dy) * PX_W'(w_s);
    pt6     <= PT_W'(dt) * PT_W'(w_s);
    ox_q[6] <= rd_old.x;
    oy_q[6] <= rd_old.y;
    ot_q[6] <= rd_old.theta;
    for (int k = 7; k <= 9; k++) begin
      ox_q[k] <= ox_q[k-1];
      oy_q[k] <= oy_q[k-1];
      ot_q[k] <= ot_q[k-1];
    end
  end

  lppd_cdiv #(.W(PM_W), .DIV(AZ_PER_POSE)) u_div_x (
    .clk (clk),
    .mag (PM_W'(px6[PX_W-1] ? -px6 : px6)),
    .neg (px6[PX_W-1]),
    .quo (quo_x),
    .rem ()
  );

  lppd_cdiv #(.W(PM_W), .DIV(AZ_PER_POSE)) u_div_y (
    .clk (clk),
    .mag (PM_W'(py6[PX_W-1] ? -py6 : py6)),
    .neg (py6[PX_W-1]),
    .quo (quo_y),
    .rem ()
  );

  lppd_cdiv #(.W(TM_W), .DIV(AZ_PER_POSE)) u_div_t (
    .clk (clk),
    .mag (TM_W'(pt6[PT_W-1] ? -pt6 : pt6)),
    .neg (pt6[PT_W-1]),
    .quo (quo_t),
    .rem ()
  );

  // translated point and interpolated heading
  always_ff @(posedge clk) begin
    px_q[10] <= PS_W'(x_q[9]) + PS_W'(sox) + PS_W'(ox_q[9]) + PS_W'(quo_x);
    py_q[10] <= PS_W'(y_q[9]) + PS_W'(soy) + PS_W'(oy_q[9]) + PS_W'(quo_y);
    th10     <= DT_W'(ot_q[9]) + DT_W'(quo_t);
    for (int k = 11; k <= 16; k++) begin
      px_q[k] <= px_q[k-1];
      py_q[k] <= py_q[k-1];
    end
  end

  assign ph_full = 36'(th10) * 36'(PHASE_MUL) + 36'(PHASE_ROUND);

  always_ff @(posedge clk) begin
    phase11 <= ph_full[31:16];
  end

  lppd_sine u_sin (
    .clk   (clk),
    .phase (phase11),
    .sine  (sin16)
  );

  lppd_sine u_cos (
    .clk   (clk),
    .phase (phase11 + 16'(QUARTER)),
    .sine  (cos16)
  );

  // rotation
  always_ff @(posedge clk) begin
    cpx <= RP_W'(cos16) * RP_W'(px_q[16]);
    spy <= RP_W'(sin16) * RP_W'(py_q[16]);
    spx <= RP_W'(sin16) * RP_W'(px_q[16]);
    cpy <= RP_W'(cos16) * RP_W'(py_q[16]);
  end

  assign rx_full = (RP_W+1)'(cpx) - (RP_W+1)'(spy) + (RP_W+1)'(ROT_ROUND);
  assign ry_full = (RP_W+1)'(spx) + (RP_W+1)'(cpy) + (RP_W+1)'(ROT_ROUND);
  assign rx_off  = (rx_full >>> Q_FRAC) - (RP_W+1)'(sox);
  assign ry_off  = (ry_full >>> Q_FRAC) - (RP_W+1)'(soy);
  assign ok17    = (side_q[LAT-1].cmd == CMD_POINT) && (side_q[LAT-1].status == ST_OK);

  always_ff @(posedge clk) begin
    out_x  <= ok17 ? sat_x(rx_off) : '0;
    out_y  <= ok17 ? sat_x(ry_off) : '0;
    status <= side_q[LAT-1].status;
  end

  `ASSERT_CLK(a_latency, clk, rst, accept |-> ##LAT done, "result missing after pipeline latency")
  `ASSERT_CLK(a_err_zero, clk, rst, (done && status != ST_OK) |-> (out_x == '0 && out_y == '0), "error result carries data")
  `ASSERT_CLK(a_count_max, clk, rst, count <= CW'(POSE_DEPTH), "pose count above ring depth")
  `ASSERT_NEXT(a_head_step, clk, rst, accept && cmd == CMD_POSE, head == (($past(head) == HW'(POSE_DEPTH - 1)) ? '0 : $past(head) + 1'b1), "ring head did not advance")

endmodule

>>> tb/sv/lidar_point_pose_deskew_core_tb.sv
// testbench of the lidar point motion deskew core with its own pose-ring predictor
`timescale 1ns / 100ps
module lidar_point_pose_deskew_core_tb;
  import lppd_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RING = 64;
  localparam int AZ_STEP = 180;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic signed [X_W-1:0] x;
    logic signed [X_W-1:0] y;
    logic [ST_W-1:0]       st;
  } point_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [CMD_W-1:0] cmd = CMD_POSE;
  logic signed [X_W-1:0] in_x = '0;
  logic signed [X_W-1:0] in_y = '0;
  logic signed [TH_W-1:0] in_theta = '0;
  logic [AZ_W-1:0] azimuth = '0;
  logic signed [TOFF_W-1:0] time_offset = '0;
  logic wr_en = 1'b0;
  logic wr_index = REG_SENSOR_X;
  logic [CFG_W-1:0] wr_data = '0;
  logic done;
  logic signed [X_W-1:0] out_x;
  logic signed [X_W-1:0] out_y;
  logic [ST_W-1:0] status;

  lidar_point_pose_deskew_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .in_x(in_x),
    .in_y(in_y), .in_theta(in_theta), .azimuth(azimuth), .time_offset(time_offset),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data), .done(done),
    .out_x(out_x), .out_y(out_y), .status(status)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // predictor state
  longint ring_x [RING];
  longint ring_y [RING];
  longint ring_th [RING];
  int pose_head = 0;
  int pose_count = 0;
  longint ref_az = 0;
  longint scan_off = 0;
  longint mount_x = 0;
  longint mount_y = 0;

  point_res_t deskew_q[$];
  int errors = 0;
  int n_sent = 0;
  int idle_cycles = 0;
  bit no_gaps = 1'b0;

  function automatic longint sine_q14(longint ph);
    longint p, q, r, x2, t, s;
    p = ph & 65535;
    q = p >> 14;
    r = p & 16383;
    if (q[0]) r = QUARTER - r;
    x2 = (r * r) >> 14;
    t = SIN_B - ((x2 * SIN_C) >> 14);
    t = SIN_A - ((x2 * t) >> 14);
    s = (r * t) >> 14;
    return q[1] ? -s : s;
  endfunction

  function automatic longint blend(longint older, longint newer, longint w);
    return older + ((newer - older) * w) / AZ_STEP;
  endfunction

  function automatic longint clip24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic point_res_t deskew_predict(logic [CMD_W-1:0] c, longint px_in,
      longint py_in, longint th_in, longint az, longint toff);
    point_res_t r;
    longint off, num, w, px, py, th, ph, s, co, rx, ry;
    int inew, iold;
    r = '0;
    rx = 0;
    ry = 0;
    case (c)
      CMD_POSE: begin
        ring_x[pose_head] = px_in;
        ring_y[pose_head] = py_in;
        ring_th[pose_head] = th_in;
        pose_head = (pose_head + 1) % RING;
        if (pose_count < RING) pose_count++;
      end
      CMD_SCAN: begin
        ref_az = az;
        scan_off = toff;
      end
      CMD_POINT: begin
        off = ref_az - az + scan_off;
        if (off < 0) begin
          r.st = ST_NEG;
        end else begin
          num = off / AZ_STEP;
          w = AZ_STEP - off % AZ_STEP;
          if (num + 2 > pose_count) begin
            r.st = ST_RANGE;
          end else begin
            inew = (pose_head + RING - 1 - int'(num)) % RING;
            iold = (pose_head + 2 * RING - 2 - int'(num)) % RING;
            px = px_in + mount_x + blend(ring_x[iold], ring_x[inew], w);
            py = py_in + mount_y + blend(ring_y[iold], ring_y[inew], w);
            th = blend(ring_th[iold], ring_th[inew], w);
            ph = (th * PHASE_MUL + PHASE_ROUND) >>> 16;
            s = sine_q14(ph);
            co = sine_q14(ph + QUARTER);
            rx = clip24(((co * px - s * py + ROT_ROUND) >>> 14) - mount_x);
            ry = clip24(((s * px + co * py + ROT_ROUND) >>> 14) - mount_y);
            r.st = ST_OK;
          end
        end
      end
      default: ;
    endcase
    r.x = rx[X_W-1:0];
    r.y = ry[X_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s at %0t: got %0d expected %0d", what, $realtime, got, want);
    errors++;
  endtask

  task automatic send_item(logic [CMD_W-1:0] c, longint x, longint y, longint th,
      longint az, longint toff);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 13);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    cmd <= c;
    in_x <= x[X_W-1:0];
    in_y <= y[X_W-1:0];
    in_theta <= th[TH_W-1:0];
    azimuth <= az[AZ_W-1:0];
    time_offset <= toff[TOFF_W-1:0];
    while (busy) begin
      @(negedge clk);
    end
    @(posedge clk);
    deskew_q = {deskew_q, deskew_predict(c, x, y, th, az, toff)};
    n_sent++;
    if ($urandom_range(0, 49) == 0) no_gaps = ~no_gaps;
  endtask

  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    while (deskew_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_mount(logic idx, longint v);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= v[CFG_W-1:0];
    @(negedge clk);
    wr_en <= 1'b0;
    if (idx == REG_SENSOR_X) mount_x = v;
    else mount_y = v;
  endtask

  // result checker
  always @(posedge clk) begin
    point_res_t e;
    if (!rst && done) begin
      if (deskew_q.size() == 0) begin
        report_mismatch("unexpected transaction", status, -1);
      end else begin
        e = deskew_q.pop_front();
        if (out_x !== e.x) report_mismatch("out_x", out_x, e.x);
        if (out_y !== e.y) report_mismatch("out_y", out_y, e.y);
        if (status !== e.st) report_mismatch("status", status, e.st);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("lidar_point_pose_deskew_core test failed");
      $finish;
    end
  end

  task automatic test_directed;
    send_item(CMD_POINT, 0, 0, 0, 0, 0);
    send_item(CMD_POINT, 5, 5, 0, 1, 0);
    send_item(CMD_UNUSED, -1, -1, -1, 35999, -1);
    send_item(CMD_POSE, 8388607, -8388608, 32767, 0, 0);
    send_item(CMD_POSE, -8388608, 8388607, -32768, 0, 0);
    send_item(CMD_POSE, 0, 0, 0, 0, 0);
    send_item(CMD_SCAN, 0, 0, 0, 35999, 0);
    send_item(CMD_POINT, 8388607, 8388607, 0, 35999, 0);
    send_item(CMD_POINT, -8388608, -8388608, 0, 35999 - 179, 0);
    send_item(CMD_POINT, 1000, -1000, 0, 35999 - 180, 0);
    send_item(CMD_POINT, 1000, -1000, 0, 35999 - 360, 0);
    send_item(CMD_POINT, 0, 0, 0, 0, 0);
    send_item(CMD_SCAN, 0, 0, 0, 0, 32767);
    send_item(CMD_POINT, 1, 1, 0, 0, 0);
    send_item(CMD_POINT, 1, 1, 0, 35999, 0);
    send_item(CMD_SCAN, 0, 0, 0, 35999, -32768);
    send_item(CMD_POINT, 1, 1, 0, 0, 0);
    send_item(CMD_SCAN, 0, 0, 0, 200, 100);
    send_item(CMD_POINT, -4096, 4096, 0, 0, 0);
    send_item(CMD_POINT, 4096, 4096, 0, 150, 0);
    send_item(CMD_POINT, 8388607, -8388608, 0, 300, 0);
    drain();
  endtask

  task automatic random_sequences(int quota);
    int n, m, span;
    longint x, y, th, r_az, toff, off, az;
    while (quota > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(CMD_W'($urandom_range(0, 3)), $signed(24'($urandom)),
                  $signed(24'($urandom)), $signed(16'($urandom)),
                  $urandom_range(0, 35999), $signed(16'($urandom)));
        quota--;
      end else begin
        n = $urandom_range(1, 70);
        x = $signed(24'($urandom));
        y = $signed(24'($urandom));
        th = $signed(16'($urandom));
        repeat (n) begin
          if ($urandom_range(0, 7) == 0) begin
            x = $signed(24'($urandom));
            y = $signed(24'($urandom));
            th = $signed(16'($urandom));
          end else begin
            x = $signed(24'(x + $signed($urandom_range(0, 8000)) - 4000));
            y = $signed(24'(y + $signed($urandom_range(0, 8000)) - 4000));
            th = $signed(16'(th + $signed($urandom_range(0, 2000)) - 1000));
          end
          send_item(CMD_POSE, x, y, th, $urandom_range(0, 35999), $signed(16'($urandom)));
        end
        r_az = $urandom_range(0, 35999);
        toff = ($urandom_range(0, 7) == 0) ? longint'($signed(16'($urandom)))
                                           : longint'($urandom_range(0, 600)) - 200;
        send_item(CMD_SCAN, $signed(24'($urandom)), $signed(24'($urandom)),
                  $signed(16'($urandom)), r_az, toff);
        m = $urandom_range(1, 30);
        span = AZ_STEP * (pose_count > 1 ? pose_count - 1 : 1);
        repeat (m) begin
          off = longint'($urandom_range(0, span + 40)) - 20;
          az = r_az + toff - off;
          if (az < 0 || az > 35999) az = $urandom_range(0, 35999);
          if ($urandom_range(0, 3) == 0) begin
            x = $signed(24'($urandom));
            y = $signed(24'($urandom));
          end else begin
            x = longint'($urandom_range(0, 200000)) - 100000;
            y = longint'($urandom_range(0, 200000)) - 100000;
          end
          send_item(CMD_POINT, x, y, $signed(16'($urandom)), az, $signed(16'($urandom)));
        end
        quota -= n + m + 1;
      end
    end
    drain();
  endtask

  task automatic test_mount_extremes;
    write_mount(REG_SENSOR_X, 65535);
    write_mount(REG_SENSOR_Y, -65536);
    random_sequences(360);
    write_mount(REG_SENSOR_X, -65536);
    write_mount(REG_SENSOR_Y, 65535);
    random_sequences(360);
  endtask

  task automatic test_mount_random;
    write_mount(REG_SENSOR_X, longint'($urandom_range(0, 131071)) - 65536);
    write_mount(REG_SENSOR_Y, longint'($urandom_range(0, 131071)) - 65536);
    random_sequences(360);
    write_mount(REG_SENSOR_X, 0);
    write_mount(REG_SENSOR_Y, 0);
    random_sequences(340);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_mount_extremes();
    test_mount_random();
    repeat (40) @(posedge clk);
    if (errors == 0 && deskew_q.size() == 0) begin
      $display("lidar_point_pose_deskew_core test passed");
    end else begin
      $display("lidar_point_pose_deskew_core test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/lppd_pkg.sv
design/lppd_ring.sv
design/lppd_cdiv.sv
design/lppd_sine.sv
design/lidar_point_pose_deskew_core.sv
tb/sv/lidar_point_pose_deskew_core_tb.sv
